[src/bps_pkg.sv]
// Shared types and constants for the binned pattern similarity unit.
`timescale 1ns / 1ps
`default_nettype none
package bps_pkg;

  // Metric codes held in the configuration register.
  localparam logic [1:0] METRIC_COSINE = 2'd0;
  localparam logic [1:0] METRIC_INTERSECT = 2'd1;
  localparam logic [1:0] METRIC_EUCLID = 2'd2;

  // Q1.16 value of 1.0.
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Sequencer step counts.
  localparam int DIV_STEPS = 82;
  localparam int SQRT_STEPS = 16;

  // Datapath operation codes.
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_PREP = 4'd1;
  localparam logic [3:0] OP_DIV_LOAD = 4'd2;
  localparam logic [3:0] OP_DIV_STEP = 4'd3;
  localparam logic [3:0] OP_SQRT_LOAD = 4'd4;
  localparam logic [3:0] OP_SQRT_STEP = 4'd5;
  localparam logic [3:0] OP_EUC_SQ = 4'd6;
  localparam logic [3:0] OP_EUC_LO = 4'd7;
  localparam logic [3:0] OP_EUC_HI = 4'd8;
  localparam logic [3:0] OP_EUC_CMP = 4'd9;
  localparam logic [3:0] OP_LOAD = 4'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       acc;
    logic [3:0] op;
  } bps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] metric;
    logic       zero_case;
    logic       search_done;
    logic       out_free;
  } bps_status_t;

endpackage
`default_nettype wire

[src/binned_pattern_similarity_unit.sv]
// Binned pattern similarity: cosine, histogram intersection or euclidean similarity.
//
// Input stream: one pair of 8-bit bin counts per transfer, tlast on the final pair.
// Pairs are taken one per cycle while a pattern accumulates. After the final
// pair the block stops taking input while it computes the result; the steps
// from the final pair to the load of the output:
//   cosine: setup, long division, square root, load;
//   intersection: setup, long division, load;
//   euclidean: setup, then a binary search of at most 17 steps, then load;
//   a zero norm or union, or the unused metric code: setup, then load.
// The result then goes to an output register and input is taken again, so
// the next pattern may stream in while the result waits on the output.
// If the receiver stalls and a second result is ready, the block holds until
// the output register frees. Output: similarity as unsigned Q1.16, with
// too_long in tuser when more than MAX_BINS pairs arrived. The metric register is
// to be written through cfg_we / cfg_wdata while idle; the block does not enforce
// this. Reset clears the accumulators, selects cosine and empties the output.
`timescale 1ns / 1ps
`default_nettype none
module binned_pattern_similarity_unit
  import bps_pkg::*;
#(
  parameter int MAX_BINS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // bin_a [7:0], bin_b [15:8]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // similarity [16:0], zeros [23:17]
  output logic [0:0]       m_axis_tuser   // too_long [0]
);

  bps_cmd_t    cmd;
  bps_status_t status;
  logic [16:0] similarity;
  logic        too_long;

  // Sequencing.
  bps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and storage.
  bps_datapath #(
    .MAX_BINS (MAX_BINS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .bin_a      (s_axis_tdata[7:0]),
    .bin_b      (s_axis_tdata[15:8]),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .similarity (similarity),
    .too_long   (too_long)
  );

  // Output packing.
  assign m_axis_tdata = {7'd0, similarity};
  assign m_axis_tuser = too_long;

endmodule
`default_nettype wire

[src/bps_ctrl.sv]
// Controller state machine that sequences accumulation and the result computation.
`timescale 1ns / 1ps
`default_nettype none
module bps_ctrl
  import bps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_last,
  output logic             in_ready,
  input  wire bps_status_t status,
  output bps_cmd_t         cmd
);

  localparam logic [3:0] ST_ACC = 4'd0;
  localparam logic [3:0] ST_PREP = 4'd1;
  localparam logic [3:0] ST_DIV_LOAD = 4'd2;
  localparam logic [3:0] ST_DIV = 4'd3;
  localparam logic [3:0] ST_SQRT_LOAD = 4'd4;
  localparam logic [3:0] ST_SQRT = 4'd5;
  localparam logic [3:0] ST_EM1 = 4'd6;
  localparam logic [3:0] ST_EM2 = 4'd7;
  localparam logic [3:0] ST_EM3 = 4'd8;
  localparam logic [3:0] ST_EM4 = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [6:0] step_cnt;
  logic [6:0] step_cnt_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    step_cnt_next = step_cnt + 7'd1;
    in_ready = 1'b0;
    cmd.acc = 1'b0;
    cmd.op = OP_NONE;
    case (state)
      ST_ACC: begin
        in_ready = 1'b1;
        cmd.acc = in_valid;
        if (in_valid && in_last) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.op = OP_PREP;
        case (status.metric)
          METRIC_COSINE, METRIC_INTERSECT: begin
            state_next = status.zero_case ? ST_DONE : ST_DIV_LOAD;
          end
          METRIC_EUCLID: state_next = ST_EM1;
          default: state_next = ST_DONE;
        endcase
      end
      ST_DIV_LOAD: begin
        cmd.op = OP_DIV_LOAD;
        step_cnt_next = 7'd0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (step_cnt == 7'(DIV_STEPS - 1)) begin
          state_next = (status.metric == METRIC_COSINE) ? ST_SQRT_LOAD : ST_DONE;
        end
      end
      ST_SQRT_LOAD: begin
        cmd.op = OP_SQRT_LOAD;
        step_cnt_next = 7'd0;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (step_cnt == 7'(SQRT_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_EM1: begin
        if (status.search_done) begin
          state_next = ST_DONE;
        end else begin
          cmd.op = OP_EUC_SQ;
          state_next = ST_EM2;
        end
      end
      ST_EM2: begin
        cmd.op = OP_EUC_LO;
        state_next = ST_EM3;
      end
      ST_EM3: begin
        cmd.op = OP_EUC_HI;
        state_next = ST_EM4;
      end
      ST_EM4: begin
        cmd.op = OP_EUC_CMP;
        state_next = ST_EM1;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.op = OP_LOAD;
          state_next = ST_ACC;
        end
      end
      default: state_next = ST_ACC;
    endcase
  end

  // State and step counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
      step_cnt <= 7'd0;
    end else begin
      state <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

endmodule
`default_nettype wire

[src/bps_datapath.sv]
// Datapath: accumulators, shared divider, square root, euclidean search and output register.
`timescale 1ns / 1ps
`default_nettype none
module bps_datapath
  import bps_pkg::*;
#(
  parameter int MAX_BINS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,
  input  wire logic [7:0]  bin_a,
  input  wire logic [7:0]  bin_b,
  input  wire bps_cmd_t    cmd,
  output bps_status_t      status,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [16:0]      similarity,
  output logic             too_long
);

  localparam int CW = $clog2(MAX_BINS + 1);

  logic [1:0]    metric;
  logic [24:0]   first_sum;
  logic [24:0]   second_sum;
  logic [24:0]   third_sum;
  logic [CW-1:0] bin_count;
  logic          overflow_seen;

  // Saturating add of a 16-bit term to a 25-bit sum.
  function automatic logic [24:0] sat_add(input logic [24:0] acc, input logic [15:0] v);
    logic [25:0] s;
    s = {1'b0, acc} + {10'd0, v};
    return s[25] ? 25'h1FFFFFF : s[24:0];
  endfunction

  // Per-pair terms.
  logic [7:0]  pmin;
  logic [7:0]  pmax;
  logic [15:0] ab;
  logic [15:0] aa;
  logic [15:0] bb;
  logic [15:0] dd;
  assign pmin = (bin_a < bin_b) ? bin_a : bin_b;
  assign pmax = (bin_a < bin_b) ? bin_b : bin_a;
  assign ab = bin_a * bin_b;
  assign aa = bin_a * bin_a;
  assign bb = bin_b * bin_b;
  assign dd = (pmax - pmin) * (pmax - pmin);

  // Working registers of the compute phase.
  logic [49:0] dot2;
  logic [49:0] prod;
  logic [81:0] divd;
  logic [49:0] divisor;
  logic [49:0] rem;
  logic [32:0] quot;
  logic        big;
  logic [31:0] sq_op;
  logic [31:0] sq_res;
  logic [31:0] sq_one;
  logic [16:0] lo;
  logic [16:0] hi;
  logic [16:0] mreg;
  logic [32:0] m2;
  logic [32:0] d2;
  logic [44:0] p_lo;
  logic [45:0] p_hi;

  // Divider step.
  logic [50:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem, divd[81]};
  assign rem_ge = rem_sh >= {1'b0, divisor};

  // Square root step.
  logic [31:0] sq_try;
  assign sq_try = sq_res + sq_one;

  // Euclidean search midpoint.
  logic [17:0] mid_sum;
  logic [16:0] mid;
  logic [16:0] gap_q16;
  logic [57:0] p_tot;
  assign mid_sum = {1'b0, lo} + {1'b0, hi} + 18'd1;
  assign mid = mid_sum[17:1];
  assign gap_q16 = ONE_Q16 - mid;
  assign p_tot = {p_hi, 12'd0} + {13'd0, p_lo};

  // Final result selection.
  logic [16:0] result;
  always_comb begin
    case (metric)
      METRIC_COSINE: begin
        if (status.zero_case) result = 17'd0;
        else if (big || quot[32]) result = ONE_Q16;
        else result = {1'b0, sq_res[15:0]};
      end
      METRIC_INTERSECT: begin
        if (status.zero_case) result = 17'd0;
        else if (big || quot > {16'd0, ONE_Q16}) result = ONE_Q16;
        else result = quot[16:0];
      end
      METRIC_EUCLID: result = lo;
      default: result = 17'd0;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    status.metric = metric;
    status.zero_case = (second_sum == 25'd0) ||
                       (metric == METRIC_COSINE && third_sum == 25'd0);
    status.search_done = (lo == hi);
    status.out_free = !out_valid || out_ready;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      metric <= METRIC_COSINE;
    end else if (cfg_we) begin
      metric <= cfg_wdata;
    end
  end

  // Accumulators, cleared at reset and when the result is loaded.
  always_ff @(posedge clk) begin
    if (rst || cmd.op == OP_LOAD) begin
      first_sum <= 25'd0;
      second_sum <= 25'd0;
      third_sum <= 25'd0;
      bin_count <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.acc) begin
      if (bin_count < CW'(MAX_BINS)) begin
        bin_count <= bin_count + 1'b1;
        case (metric)
          METRIC_COSINE: begin
            first_sum <= sat_add(first_sum, ab);
            second_sum <= sat_add(second_sum, aa);
            third_sum <= sat_add(third_sum, bb);
          end
          METRIC_INTERSECT: begin
            first_sum <= sat_add(first_sum, {8'd0, pmin});
            second_sum <= sat_add(second_sum, {8'd0, pmax});
          end
          METRIC_EUCLID: first_sum <= sat_add(first_sum, dd);
          default: ;
        endcase
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // Compute-phase registers, driven by the controller's operation code.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_PREP: begin
        dot2 <= first_sum * first_sum;
        prod <= second_sum * third_sum;
        lo <= 17'd0;
        hi <= ONE_Q16;
      end
      OP_DIV_LOAD: begin
        if (metric == METRIC_COSINE) begin
          divd <= {dot2, 32'd0};
          divisor <= prod;
        end else begin
          divd <= {41'd0, first_sum, 16'd0};
          divisor <= {25'd0, second_sum};
        end
        rem <= 50'd0;
        quot <= 33'd0;
        big <= 1'b0;
      end
      OP_DIV_STEP: begin
        divd <= {divd[80:0], 1'b0};
        rem <= rem_ge ? 50'(rem_sh - {1'b0, divisor}) : rem_sh[49:0];
        quot <= {quot[31:0], rem_ge};
        big <= big | quot[32];
      end
      OP_SQRT_LOAD: begin
        sq_op <= quot[31:0];
        sq_res <= 32'd0;
        sq_one <= 32'h4000_0000;
      end
      OP_SQRT_STEP: begin
        if (sq_op >= sq_try) begin
          sq_op <= sq_op - sq_try;
          sq_res <= {1'b0, sq_res[31:1]} + sq_one;
        end else begin
          sq_res <= {1'b0, sq_res[31:1]};
        end
        sq_one <= {2'd0, sq_one[31:2]};
      end
      OP_EUC_SQ: begin
        mreg <= mid;
        m2 <= 33'(mid * mid);
        d2 <= 33'(gap_q16 * gap_q16);
      end
      OP_EUC_LO: p_lo <= m2 * first_sum[11:0];
      OP_EUC_HI: p_hi <= m2 * first_sum[24:12];
      OP_EUC_CMP: begin
        if (p_tot <= {25'd0, d2}) lo <= mreg;
        else hi <= mreg - 17'd1;
      end
      default: ;
    endcase
  end

  // Output register; a new result loads only when the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_LOAD) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      similarity <= result;
      too_long <= overflow_seen;
    end
  end

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the binned pattern similarity unit.
`timescale 1ns / 1ps
module tb;
  import bps_pkg::*;

  localparam int MAX_PAIRS = 256;
  localparam int SUM_LIMIT = 25'h1FFFFFF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 300;
  localparam int RANDOM_ITEMS = 1900;

  typedef struct {
    logic [16:0] similarity;
    logic        too_long;
  } score_t;

  typedef struct {
    logic [1:0] metric;
    logic [7:0] a;
    logic [7:0] b;
    logic       last;
    logic       known;
    logic [16:0] similarity;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  // Predictor state.
  logic [1:0]  cur_metric;
  logic [24:0] sum1, sum2, sum3;
  int          pairs_held;
  logic        dropped;

  score_t      pending_scores[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          long_hold_req = 0;
  bit          long_hold_done = 0;

  binned_pattern_similarity_unit #(.MAX_BINS(MAX_PAIRS)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Run length guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [24:0] sat_sum(logic [24:0] acc, logic [16:0] v);
    logic [25:0] s;
    s = {1'b0, acc} + v;
    return (s > SUM_LIMIT) ? 25'(SUM_LIMIT) : s[24:0];
  endfunction

  // Similarity from the held sums, as the floor of the exact value.
  function automatic logic [16:0] similarity_of();
    logic [63:0] lo, hi, mid, prod, dot2, q, d;
    logic [127:0] lhs, rhs;
    bit ok;
    lo = 0;
    hi = 64'h10000;
    case (cur_metric)
      METRIC_COSINE: begin
        if (sum2 == 0 || sum3 == 0) return 17'd0;
        prod = 64'(sum2) * 64'(sum3);
        dot2 = 64'(sum1) * 64'(sum1);
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          lhs = 128'(mid * mid) * 128'(prod);
          rhs = 128'(dot2) << 32;
          ok = lhs <= rhs;
          if (ok) lo = mid; else hi = mid - 1;
        end
        return lo[16:0];
      end
      METRIC_INTERSECT: begin
        if (sum2 == 0) return 17'd0;
        q = (64'(sum1) << 16) / 64'(sum2);
        return (q > 64'h10000) ? ONE_Q16 : q[16:0];
      end
      METRIC_EUCLID: begin
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          d = 64'h10000 - mid;
          ok = mid * mid * 64'(sum1) <= d * d;
          if (ok) lo = mid; else hi = mid - 1;
        end
        return lo[16:0];
      end
      default: return 17'd0;
    endcase
  endfunction

  // Advance the predictor by one accepted pair.
  task automatic accumulate_pair(logic [7:0] a, logic [7:0] b, logic last);
    logic [7:0] mn, mx, df;
    score_t sc;
    mn = (a < b) ? a : b;
    mx = (a < b) ? b : a;
    df = mx - mn;
    if (pairs_held < MAX_PAIRS) begin
      pairs_held++;
      case (cur_metric)
        METRIC_COSINE: begin
          sum1 = sat_sum(sum1, 17'(a * b));
          sum2 = sat_sum(sum2, 17'(a * a));
          sum3 = sat_sum(sum3, 17'(b * b));
        end
        METRIC_INTERSECT: begin
          sum1 = sat_sum(sum1, 17'(mn));
          sum2 = sat_sum(sum2, 17'(mx));
        end
        METRIC_EUCLID: sum1 = sat_sum(sum1, 17'(df * df));
        default: ;
      endcase
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      sc.similarity = similarity_of();
      sc.too_long = dropped;
      pending_scores.insert(pending_scores.size(), sc);
      sum1 = '0; sum2 = '0; sum3 = '0;
      pairs_held = 0;
      dropped = 1'b0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one pair and wait for its transfer; returns at the accepting edge.
  task automatic send_pair(logic [7:0] a, logic [7:0] b, logic last, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, a};
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    accumulate_pair(a, b, last);
  endtask

  // Write the metric once all results are out and the block has settled.
  task automatic write_metric(logic [1:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_metric = value;
  endtask

  function automatic logic [7:0] pick_bin();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiver: random backpressure, one long hold-off on request, and checking.
  int stall_left = 0;
  always @(posedge clk) begin
    score_t want;
    int r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: sim=%0d too_long=%0d",
                   m_axis_tdata[16:0], m_axis_tuser[0]);
      end else begin
        want = pending_scores.pop_front();
        if (m_axis_tdata !== {7'd0, want.similarity} || m_axis_tuser[0] !== want.too_long) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected sim=%0d too_long=%0d, got data=%0h too_long=%0d",
                     want.similarity, want.too_long, m_axis_tdata, m_axis_tuser[0]);
        end
      end
    end
    if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1;
      stall_left <= 600;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        m_axis_tready <= 1'b1;
      end else if (r < 98) begin
        m_axis_tready <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b0;
        stall_left <= $urandom_range(20, 80);
      end
    end
  end

  // Directed rows; similarity is typed in only where it is obvious.
  stim_row_t rows[] = '{
    '{METRIC_COSINE, 8'd0, 8'd0, 1'b1, 1'b1, 17'd0},
    '{METRIC_COSINE, 8'd255, 8'd255, 1'b1, 1'b1, 17'h10000},
    '{METRIC_COSINE, 8'd255, 8'd0, 1'b1, 1'b1, 17'd0},
    '{METRIC_COSINE, 8'd3, 8'd4, 1'b0, 1'b0, 17'd0},
    '{METRIC_COSINE, 8'd4, 8'd3, 1'b1, 1'b0, 17'd0},
    '{METRIC_INTERSECT, 8'd0, 8'd0, 1'b1, 1'b1, 17'd0},
    '{METRIC_INTERSECT, 8'd255, 8'd255, 1'b1, 1'b1, 17'h10000},
    '{METRIC_INTERSECT, 8'd0, 8'd255, 1'b1, 1'b1, 17'd0},
    '{METRIC_INTERSECT, 8'd100, 8'd50, 1'b1, 1'b1, 17'd32768},
    '{METRIC_EUCLID, 8'd7, 8'd7, 1'b1, 1'b1, 17'h10000},
    '{METRIC_EUCLID, 8'd255, 8'd0, 1'b1, 1'b1, 17'd256},
    '{METRIC_EUCLID, 8'd0, 8'd255, 1'b0, 1'b0, 17'd0},
    '{METRIC_EUCLID, 8'd255, 8'd0, 1'b1, 1'b0, 17'd0},
    '{2'd3, 8'd255, 8'd255, 1'b1, 1'b1, 17'd0},
    // Metric changed in the middle of a pattern.
    '{METRIC_INTERSECT, 8'd10, 8'd20, 1'b0, 1'b0, 17'd0},
    '{METRIC_COSINE, 8'd20, 8'd10, 1'b1, 1'b0, 17'd0},
    '{METRIC_INTERSECT, 8'd200, 8'd1, 1'b0, 1'b0, 17'd0},
    '{METRIC_COSINE, 8'd1, 8'd200, 1'b1, 1'b0, 17'd0}
  };

  // Main stimulus.
  initial begin
    int sent, len, patterns;
    cur_metric = METRIC_COSINE;
    sum1 = '0; sum2 = '0; sum3 = '0;
    pairs_held = 0;
    dropped = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part; a known similarity replaces the predicted one.
    foreach (rows[i]) begin
      if (rows[i].metric != cur_metric) write_metric(rows[i].metric);
      send_pair(rows[i].a, rows[i].b, rows[i].last, pick_gap());
      if (rows[i].known) begin
        pending_scores[pending_scores.size() - 1].similarity = rows[i].similarity;
      end
    end

    // Random patterns, mostly short, a few past the bin limit.
    sent = 0;
    patterns = 0;
    while (sent < RANDOM_ITEMS) begin
      if (patterns % 8 == 0)
        write_metric(($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)));
      if (patterns == 20) long_hold_req <= 1;
      if (patterns == 44) begin
        s_axis_tvalid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge clk);
      end
      len = ($urandom_range(0, 29) == 0) ? $urandom_range(255, 270) : $urandom_range(1, 16);
      for (int k = 0; k < len; k++) begin
        send_pair(pick_bin(), pick_bin(), k == len - 1, pick_gap());
        sent++;
      end
      patterns++;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
